### rtl/fm_two_operator_voice_unit_assert.svh
// ----------------------------------------------------------------------------
// FM voice assertion macros
// Clocked assertion wrappers shared by the voice modules; they compile
// away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FM_TWO_OPERATOR_VOICE_UNIT_ASSERT_SVH
`define FM_TWO_OPERATOR_VOICE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FMV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fmv assertion failed");
`define FMV_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmv assertion failed");
`define FMV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmv assertion failed");
`else
`define FMV_ASSERT(label, prop)
`define FMV_ASSERT_IMPLY(label, ante, cons)
`define FMV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/fmv_pkg.sv
// ----------------------------------------------------------------------------
// FM voice package
// Shared types, widths, reset values and the quarter-wave sine generator.
// ----------------------------------------------------------------------------
package fmv_pkg;

    // Default parameter values
    localparam int DEFAULT_SAMPLE_BITS     = 24;
    localparam int DEFAULT_SINE_TABLE_BITS = 10;
    localparam int DEFAULT_LENGTH_BITS     = 24;

    // Fixed field widths
    localparam int PHASE_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int ENV_W      = 16;
    localparam int ROM_W      = 16;
    localparam int NOTE_CFG_W = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Shared multiplier: 32 x 16 into 48
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Deviation is the product shifted right by this many bits
    localparam int DEV_SHIFT = 11;

    localparam logic [ENV_W-1:0]  ENV_FULL     = '1;
    localparam logic [GAIN_W-1:0] DECAY_RESET  = '1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Sine polynomial coefficients, Q30
    localparam logic [63:0] SIN_C1 = 64'd1686629713;
    localparam logic [63:0] SIN_C3 = 64'd693598668;
    localparam logic [63:0] SIN_C5 = 64'd85569306;
    localparam logic [63:0] SIN_C7 = 64'd5026995;
    localparam logic [63:0] SIN_C9 = 64'd172272;
    localparam logic [63:0] SIN_MAX = 64'd32767;
    localparam logic [63:0] SIN_ROUND = 64'd16384;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CARRIER_INC   = 3'd0,
        CFG_MODULATOR_INC = 3'd1,
        CFG_MOD_INDEX     = 3'd2,
        CFG_AMPLITUDE     = 3'd3,
        CFG_DECAY         = 3'd4,
        CFG_NOTE_LENGTH   = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_RESTART,
        KIND_NOTE
    } kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DEV_MUL,
        BK_DEV_ADD,
        BK_CAR_READ,
        BK_VOICE_MUL,
        BK_VOICE_SCALE,
        BK_DONE
    } back_state_t;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        op_t  op;
    } q_status_t;

    // Quarter-wave entry: round(sin(pi/2 * idx / 2^tbits) * 2^15), clamped
    function automatic logic [ROM_W-1:0] sine_entry(input int unsigned idx,
                                                    input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] r;
        x  = 64'(idx) << (30 - tbits);
        x2 = (x * x) >> 30;
        p  = SIN_C9;
        p  = SIN_C7 - ((x2 * p) >> 30);
        p  = SIN_C5 - ((x2 * p) >> 30);
        p  = SIN_C3 - ((x2 * p) >> 30);
        p  = SIN_C1 - ((x2 * p) >> 30);
        r  = (x * p) >> 30;
        r  = (r + SIN_ROUND) >> 15;
        if (r > SIN_MAX)
        begin
            r = SIN_MAX;
        end
        return r[ROM_W-1:0];
    endfunction

endpackage

### rtl/fm_two_operator_voice_unit.sv
// ----------------------------------------------------------------------------
// Two-operator FM voice unit
// Each input item is a stereo mix pair with func = 0 for a sample tick or
// func = 1 to restart the note at full envelope. Each item yields one result
// item: the inputs plus the voice sample (saturated), the voice sample and
// the active flag. Both channels use valid/stall; the config channel writes
// one register per valid && ready and is always ready.
// The engine works on one item at a time: an active tick runs through the
// deviation, carrier and voice steps on the single 32x16 multiplier, used five
// times per sample, and the single sine ROM read port, used twice; a restart or
// an inactive tick goes straight to the last step.
// A two-entry queue takes items while the engine works; in_stall rises when
// it is full. A stalled result holds in the output register; the engine
// finishes the next item and waits in its last step until the register frees.
// Reset clears phases and position, sets the envelope to full scale and the
// decay factor to 65535, and clears the other config and control registers.
// ----------------------------------------------------------------------------
module fm_two_operator_voice_unit #(
    parameter int SAMPLE_BITS     = fmv_pkg::DEFAULT_SAMPLE_BITS,
    parameter int SINE_TABLE_BITS = fmv_pkg::DEFAULT_SINE_TABLE_BITS,
    parameter int LENGTH_BITS     = fmv_pkg::DEFAULT_LENGTH_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fmv_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  logic [fmv_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic signed [SAMPLE_BITS-1:0]    left_in,
    input  logic signed [SAMPLE_BITS-1:0]    right_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [SAMPLE_BITS-1:0]    left_out,
    output logic signed [SAMPLE_BITS-1:0]    right_out,
    output logic signed [SAMPLE_BITS-1:0]    voice_sample,
    output logic                             active
);

    logic [fmv_pkg::PHASE_W-1:0] carrier_inc_reg;
    logic [fmv_pkg::PHASE_W-1:0] modulator_inc_reg;
    logic [fmv_pkg::GAIN_W-1:0]  mod_index_reg;
    logic [fmv_pkg::GAIN_W-1:0]  amplitude_reg;
    logic [fmv_pkg::GAIN_W-1:0]  decay_reg;
    logic [LENGTH_BITS-1:0]      note_length_reg;
    logic                        cfg_write;

    fmv_pkg::q_status_t            q;
    logic signed [SAMPLE_BITS-1:0] q_left;
    logic signed [SAMPLE_BITS-1:0] q_right;
    logic                          pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_inc_reg   <= '0;
            modulator_inc_reg <= '0;
            mod_index_reg     <= '0;
            amplitude_reg     <= '0;
            decay_reg         <= fmv_pkg::DECAY_RESET;
            note_length_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (fmv_pkg::cfg_reg_t'(cfg_index))
                fmv_pkg::CFG_CARRIER_INC:
                begin
                    carrier_inc_reg <= cfg_data;
                end
                fmv_pkg::CFG_MODULATOR_INC:
                begin
                    modulator_inc_reg <= cfg_data;
                end
                fmv_pkg::CFG_MOD_INDEX:
                begin
                    mod_index_reg <= cfg_data[fmv_pkg::GAIN_W-1:0];
                end
                fmv_pkg::CFG_AMPLITUDE:
                begin
                    amplitude_reg <= cfg_data[fmv_pkg::GAIN_W-1:0];
                end
                fmv_pkg::CFG_DECAY:
                begin
                    decay_reg <= cfg_data[fmv_pkg::GAIN_W-1:0];
                end
                fmv_pkg::CFG_NOTE_LENGTH:
                begin
                    note_length_reg <= LENGTH_BITS'(cfg_data[fmv_pkg::NOTE_CFG_W-1:0]);
                end
                default:
                begin
                    note_length_reg <= note_length_reg;
                end
            endcase
        end
    end

    fmv_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .left_in  (left_in),
        .right_in (right_in),
        .pop      (pop),
        .q        (q),
        .q_left   (q_left),
        .q_right  (q_right)
    );

    fmv_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .LENGTH_BITS     (LENGTH_BITS)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q                   (q),
        .q_left              (q_left),
        .q_right             (q_right),
        .pop                 (pop),
        .carrier_increment   (carrier_inc_reg),
        .modulator_increment (modulator_inc_reg),
        .modulation_index    (mod_index_reg),
        .amplitude           (amplitude_reg),
        .decay_factor        (decay_reg),
        .note_length         (note_length_reg),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .left_out            (left_out),
        .right_out           (right_out),
        .voice_sample        (voice_sample),
        .active              (active)
    );

endmodule

### rtl/fmv_sine_rom.sv
// ----------------------------------------------------------------------------
// FM voice sine ROM
// Quarter-wave sine table with a registered read port.
// ----------------------------------------------------------------------------
module fmv_sine_rom #(
    parameter int TABLE_BITS = fmv_pkg::DEFAULT_SINE_TABLE_BITS
) (
    input  logic                       clk,
    input  logic [TABLE_BITS:0]        addr,
    output logic [fmv_pkg::ROM_W-1:0]  rd_data
);

    localparam int QUARTER = 1 << TABLE_BITS;

    logic [fmv_pkg::ROM_W-1:0] rom [QUARTER+1];
    logic [fmv_pkg::ROM_W-1:0] rd_data_reg;

    // Build the constant table
    for (genvar gi = 0; gi <= QUARTER; gi++)
    begin : g_rom
        assign rom[gi] = fmv_pkg::sine_entry(gi, TABLE_BITS);
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= rom[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/fmv_front.sv
// ----------------------------------------------------------------------------
// FM voice front end
// Accepts items, classifies them as tick or restart and holds them in a
// short queue until the back end takes them.
// ----------------------------------------------------------------------------
`include "fm_two_operator_voice_unit_assert.svh"

module fmv_front #(
    parameter int SAMPLE_BITS = fmv_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    input  logic                          pop,
    output fmv_pkg::q_status_t            q,
    output logic signed [SAMPLE_BITS-1:0] q_left,
    output logic signed [SAMPLE_BITS-1:0] q_right
);

    localparam int DEPTH = fmv_pkg::QUEUE_DEPTH;
    localparam int PTR_W = fmv_pkg::QUEUE_PTR_W;
    localparam int CNT_W = fmv_pkg::QUEUE_CNT_W;

    fmv_pkg::op_t                op_mem    [DEPTH];
    logic signed [SAMPLE_BITS-1:0] left_mem  [DEPTH];
    logic signed [SAMPLE_BITS-1:0] right_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    fmv_pkg::op_t     in_op;

    // Classify the incoming item
    assign in_op    = func ? fmv_pkg::OP_RESTART : fmv_pkg::OP_TICK;
    assign in_stall = (count_reg == CNT_W'(DEPTH));
    assign push     = in_valid && !in_stall;

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Store the item payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]    <= in_op;
            left_mem[wr_ptr_reg]  <= left_in;
            right_mem[wr_ptr_reg] <= right_in;
        end
    end

    // Present the queue head
    assign q.valid = (count_reg != '0);
    assign q.op    = op_mem[rd_ptr_reg];
    assign q_left  = left_mem[rd_ptr_reg];
    assign q_right = right_mem[rd_ptr_reg];

    `FMV_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `FMV_ASSERT_IMPLY(a_pop_nonempty, pop, count_reg != '0)
    `FMV_ASSERT_IMPLY(a_push_room, push, count_reg < CNT_W'(DEPTH))

endmodule

### rtl/fmv_back.sv
// ----------------------------------------------------------------------------
// FM voice back end
// Sequences one item at a time through a shared 32x16 multiplier and the
// sine ROM, keeps the voice state and drives the output register.
// ----------------------------------------------------------------------------
`include "fm_two_operator_voice_unit_assert.svh"

module fmv_back #(
    parameter int SAMPLE_BITS     = fmv_pkg::DEFAULT_SAMPLE_BITS,
    parameter int SINE_TABLE_BITS = fmv_pkg::DEFAULT_SINE_TABLE_BITS,
    parameter int LENGTH_BITS     = fmv_pkg::DEFAULT_LENGTH_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fmv_pkg::q_status_t             q,
    input  logic signed [SAMPLE_BITS-1:0]  q_left,
    input  logic signed [SAMPLE_BITS-1:0]  q_right,
    output logic                           pop,
    input  logic [fmv_pkg::PHASE_W-1:0]    carrier_increment,
    input  logic [fmv_pkg::PHASE_W-1:0]    modulator_increment,
    input  logic [fmv_pkg::GAIN_W-1:0]     modulation_index,
    input  logic [fmv_pkg::GAIN_W-1:0]     amplitude,
    input  logic [fmv_pkg::GAIN_W-1:0]     decay_factor,
    input  logic [LENGTH_BITS-1:0]         note_length,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_BITS-1:0]  left_out,
    output logic signed [SAMPLE_BITS-1:0]  right_out,
    output logic signed [SAMPLE_BITS-1:0]  voice_sample,
    output logic                           active
);

    localparam int PHASE_W = fmv_pkg::PHASE_W;
    localparam int ENV_W   = fmv_pkg::ENV_W;
    localparam int MUL_A_W = fmv_pkg::MUL_A_W;
    localparam int MUL_B_W = fmv_pkg::MUL_B_W;
    localparam int PROD_W  = fmv_pkg::PROD_W;
    localparam int ADDR_W  = SINE_TABLE_BITS + 1;
    localparam int QUARTER = 1 << SINE_TABLE_BITS;
    localparam int SIGN_B  = PHASE_W - 1;
    localparam int MIRROR_B = PHASE_W - 2;
    localparam int DEV_LO  = fmv_pkg::DEV_SHIFT;
    localparam int DEV_HI  = fmv_pkg::DEV_SHIFT + PHASE_W - 1;

    fmv_pkg::back_state_t state_reg;
    fmv_pkg::back_state_t state_next;
    fmv_pkg::kind_t       kind_reg;
    logic                 act_reg;

    logic [PHASE_W-1:0]     car_phase_reg;
    logic [PHASE_W-1:0]     modulator_phase_reg;
    logic [LENGTH_BITS-1:0] position_reg;
    logic [ENV_W-1:0]       env_reg;

    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic signed [SAMPLE_BITS-1:0] voice_reg;
    logic [PHASE_W-1:0]            ph_reg;
    logic [PROD_W-1:0]             prod_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;
    logic signed [SAMPLE_BITS-1:0] voice_out_reg;
    logic                          active_reg;

    logic                      mul_en;
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic                      rom_car_sel;
    logic                      out_load;
    logic [ADDR_W-1:0]         mod_addr;
    logic [ADDR_W-1:0]         car_addr;
    logic [ADDR_W-1:0]         rom_addr;
    logic [fmv_pkg::ROM_W-1:0] rom_data;
    logic                      tick_act;
    logic [PHASE_W-1:0]        dev_mag;
    logic [PHASE_W-1:0]        dev;
    logic [SAMPLE_BITS-1:0]    vmag;
    logic signed [SAMPLE_BITS-1:0] voice_calc;
    logic signed [SAMPLE_BITS:0]   left_sum;
    logic signed [SAMPLE_BITS:0]   right_sum;
    logic signed [SAMPLE_BITS-1:0] left_sat;
    logic signed [SAMPLE_BITS-1:0] right_sat;
    logic                          back_idle;
    logic                          note_load;

    // Quarter-wave addressing: mirror in odd quadrants
    assign mod_addr = modulator_phase_reg[MIRROR_B] ?
        (ADDR_W'(QUARTER) - ADDR_W'(modulator_phase_reg[MIRROR_B-1 -: SINE_TABLE_BITS])) :
        ADDR_W'(modulator_phase_reg[MIRROR_B-1 -: SINE_TABLE_BITS]);
    assign car_addr = ph_reg[MIRROR_B] ?
        (ADDR_W'(QUARTER) - ADDR_W'(ph_reg[MIRROR_B-1 -: SINE_TABLE_BITS])) :
        ADDR_W'(ph_reg[MIRROR_B-1 -: SINE_TABLE_BITS]);
    assign rom_addr = rom_car_sel ? car_addr : mod_addr;

    fmv_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk     (clk),
        .addr    (rom_addr),
        .rd_data (rom_data)
    );

    assign tick_act = (position_reg < note_length);

    // Deviation and voice magnitude from the product register
    assign dev_mag    = prod_reg[DEV_HI:DEV_LO];
    assign dev        = modulator_phase_reg[SIGN_B] ? (PHASE_W'(0) - dev_mag) : dev_mag;
    assign vmag       = prod_reg[PROD_W-1 -: SAMPLE_BITS];
    assign voice_calc = ph_reg[SIGN_B] ? -$signed(vmag) : $signed(vmag);

    // Saturating mix
    assign left_sum  = (SAMPLE_BITS+1)'(left_reg) + (SAMPLE_BITS+1)'(voice_reg);
    assign right_sum = (SAMPLE_BITS+1)'(right_reg) + (SAMPLE_BITS+1)'(voice_reg);

    always_comb
    begin
        if (left_sum[SAMPLE_BITS] != left_sum[SAMPLE_BITS-1])
        begin
            left_sat = {left_sum[SAMPLE_BITS], {(SAMPLE_BITS-1){~left_sum[SAMPLE_BITS]}}};
        end
        else
        begin
            left_sat = left_sum[SAMPLE_BITS-1:0];
        end
        if (right_sum[SAMPLE_BITS] != right_sum[SAMPLE_BITS-1])
        begin
            right_sat = {right_sum[SAMPLE_BITS], {(SAMPLE_BITS-1){~right_sum[SAMPLE_BITS]}}};
        end
        else
        begin
            right_sat = right_sum[SAMPLE_BITS-1:0];
        end
    end

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next  = state_reg;
        pop         = 1'b0;
        mul_en      = 1'b0;
        mul_a       = MUL_A_W'(env_reg);
        mul_b       = modulation_index;
        rom_car_sel = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            fmv_pkg::BK_IDLE:
            begin
                if (q.valid)
                begin
                    pop    = 1'b1;
                    mul_en = 1'b1;
                    if (q.op == fmv_pkg::OP_TICK && tick_act)
                    begin
                        state_next = fmv_pkg::BK_DEV_MUL;
                    end
                    else
                    begin
                        state_next = fmv_pkg::BK_DONE;
                    end
                end
            end
            fmv_pkg::BK_DEV_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = prod_reg[MUL_A_W-1:0];
                mul_b      = rom_data;
                state_next = fmv_pkg::BK_DEV_ADD;
            end
            fmv_pkg::BK_DEV_ADD:
            begin
                state_next = fmv_pkg::BK_CAR_READ;
            end
            fmv_pkg::BK_CAR_READ:
            begin
                mul_en      = 1'b1;
                mul_b       = amplitude;
                rom_car_sel = 1'b1;
                state_next  = fmv_pkg::BK_VOICE_MUL;
            end
            fmv_pkg::BK_VOICE_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = prod_reg[MUL_A_W-1:0];
                mul_b      = rom_data;
                state_next = fmv_pkg::BK_VOICE_SCALE;
            end
            fmv_pkg::BK_VOICE_SCALE:
            begin
                mul_en     = 1'b1;
                mul_b      = decay_factor;
                state_next = fmv_pkg::BK_DONE;
            end
            fmv_pkg::BK_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
                if (out_load)
                begin
                    state_next = fmv_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = fmv_pkg::BK_IDLE;
            end
        endcase
    end

    // Hold the output until taken
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

    // Control state and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= fmv_pkg::BK_IDLE;
            kind_reg            <= fmv_pkg::KIND_PASS;
            act_reg             <= 1'b0;
            out_valid_reg       <= 1'b0;
            car_phase_reg       <= '0;
            modulator_phase_reg <= '0;
            position_reg        <= '0;
            env_reg             <= fmv_pkg::ENV_FULL;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                if (q.op == fmv_pkg::OP_RESTART)
                begin
                    kind_reg <= fmv_pkg::KIND_RESTART;
                    act_reg  <= (note_length != '0);
                end
                else
                begin
                    kind_reg <= tick_act ? fmv_pkg::KIND_NOTE : fmv_pkg::KIND_PASS;
                    act_reg  <= tick_act;
                end
            end
            // Advance the voice when the result is loaded into the output register
            if (out_load)
            begin
                case (kind_reg)
                    fmv_pkg::KIND_RESTART:
                    begin
                        position_reg <= '0;
                        env_reg      <= fmv_pkg::ENV_FULL;
                    end
                    fmv_pkg::KIND_NOTE:
                    begin
                        car_phase_reg       <= car_phase_reg + carrier_increment;
                        modulator_phase_reg <= modulator_phase_reg + modulator_increment;
                        env_reg             <= prod_reg[2*ENV_W-1:ENV_W];
                        position_reg        <= position_reg + LENGTH_BITS'(1);
                    end
                    default:
                    begin
                        position_reg <= position_reg;
                    end
                endcase
            end
        end
    end

    // Shared multiplier
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    // Item payload and intermediate values
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            left_reg  <= q_left;
            right_reg <= q_right;
            voice_reg <= '0;
        end
        else if (state_reg == fmv_pkg::BK_VOICE_SCALE)
        begin
            voice_reg <= voice_calc;
        end
        if (state_reg == fmv_pkg::BK_DEV_ADD)
        begin
            ph_reg <= car_phase_reg + dev;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_out_reg  <= left_sat;
            right_out_reg <= right_sat;
            voice_out_reg <= voice_reg;
            active_reg    <= act_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_out     = left_out_reg;
    assign right_out    = right_out_reg;
    assign voice_sample = voice_out_reg;
    assign active       = active_reg;

    // Conditions watched by the checks
    assign back_idle = (state_reg == fmv_pkg::BK_IDLE);
    assign note_load = out_load && (kind_reg == fmv_pkg::KIND_NOTE);

    `FMV_ASSERT_NEXT(a_idle_waits, back_idle && !q.valid, back_idle)
    `FMV_ASSERT_NEXT(a_env_decays, note_load, env_reg <= $past(env_reg))
    `FMV_ASSERT_IMPLY(a_quiet_inactive, out_valid_reg && !active_reg, voice_out_reg == '0)

endmodule

### verif/fm_two_operator_voice_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FM voice unit testbench
// Drives stereo mix items and register writes into the two-operator FM voice,
// predicts every result with its own fixed-point voice predictor and checks
// the results in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module fm_two_operator_voice_unit_tb;

    localparam int SB        = fmv_pkg::DEFAULT_SAMPLE_BITS;
    localparam int TBL_BITS  = fmv_pkg::DEFAULT_SINE_TABLE_BITS;
    localparam int LB        = fmv_pkg::DEFAULT_LENGTH_BITS;
    localparam int QUARTER   = 1 << TBL_BITS;
    localparam int SETTLE    = 12;
    localparam int IDLE_LIMIT = 4000;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    typedef logic signed [SB-1:0] sample_t;

    typedef struct {
        fmv_pkg::op_t op;
        sample_t      left;
        sample_t      right;
    } mix_item_t;

    typedef struct {
        sample_t left;
        sample_t right;
        sample_t voice;
        logic    act;
    } mix_result_t;

    // Sine polynomial coefficients in Q30, highest order first
    localparam bit [63:0] POLY_C9 = 64'd172272;
    localparam bit [63:0] POLY_REST [4] = '{64'd5026995, 64'd85569306,
                                            64'd693598668, 64'd1686629713};

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [fmv_pkg::CFG_ADDR_W-1:0] cfg_index = '0;
    logic [fmv_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           func = 1'b0;
    sample_t                        left_in = '0;
    sample_t                        right_in = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    sample_t                        left_out;
    sample_t                        right_out;
    sample_t                        voice_sample;
    logic                           active;

    fm_two_operator_voice_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .left_in      (left_in),
        .right_in     (right_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_out     (left_out),
        .right_out    (right_out),
        .voice_sample (voice_sample),
        .active       (active)
    );

    // Predictor state and register copies
    bit [15:0]   quarter_wave [0:QUARTER];
    bit [31:0]   car_inc_q;
    bit [31:0]   mod_inc_q;
    bit [15:0]   mod_index_q;
    bit [15:0]   amp_q;
    bit [15:0]   decay_q;
    bit [LB-1:0] note_len_q;
    bit [31:0]   car_phase;
    bit [31:0]   modulator_phase;
    bit [LB-1:0] note_pos;
    bit [15:0]   env_level;

    mix_item_t   pending_samples [$];
    mix_result_t expected_mix [$];

    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          in_taken = 1'b0;

    always #5 clk = ~clk;

    // Build the quarter-wave table with the Q30 odd polynomial
    initial
    begin
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] p;
        bit [63:0] r;
        for (int i = 0; i <= QUARTER; i++)
        begin
            x  = 64'(i) << (30 - TBL_BITS);
            x2 = (x * x) >> 30;
            p  = POLY_C9;
            foreach (POLY_REST[k])
            begin
                p = POLY_REST[k] - ((x2 * p) >> 30);
            end
            r = (((x * p) >> 30) + 64'd16384) >> 15;
            quarter_wave[i] = (r > 64'd32767) ? 16'd32767 : r[15:0];
        end
    end

    // Sine of a phase as magnitude and sign
    function automatic void sine_lookup(input bit [31:0] ph, output bit [15:0] mag,
                                        output bit neg);
        int idx;
        idx = int'(ph[29 -: TBL_BITS]);
        mag = ph[30] ? quarter_wave[QUARTER - idx] : quarter_wave[idx];
        neg = ph[31];
    endfunction

    function automatic sample_t clamp_sum(input sample_t a, input sample_t b);
        logic signed [SB:0] s;
        s = a + b;
        if (s[SB] != s[SB-1])
        begin
            return s[SB] ? S_MIN : S_MAX;
        end
        return s[SB-1:0];
    endfunction

    // Advance the voice by one item and form its result
    function automatic mix_result_t step_voice(input mix_item_t it);
        mix_result_t res;
        bit [15:0]   m_mag;
        bit [15:0]   c_mag;
        bit          m_neg;
        bit          c_neg;
        bit [63:0]   prod;
        bit [31:0]   dev;
        bit [31:0]   env_prod;
        sample_t     vmag;
        sample_t     voice;
        voice   = '0;
        res.act = 1'b0;
        if (it.op == fmv_pkg::OP_RESTART)
        begin
            note_pos  = '0;
            env_level = fmv_pkg::ENV_FULL;
            res.act   = (note_len_q != '0);
        end
        else if (note_pos < note_len_q)
        begin
            res.act = 1'b1;
            sine_lookup(modulator_phase, m_mag, m_neg);
            prod = (64'(mod_index_q) * 64'(env_level) * 64'(m_mag)) >> fmv_pkg::DEV_SHIFT;
            dev  = prod[31:0];
            if (m_neg)
            begin
                dev = -dev;
            end
            sine_lookup(car_phase + dev, c_mag, c_neg);
            prod  = (64'(c_mag) * 64'(env_level) * 64'(amp_q)) >> (48 - SB);
            vmag  = prod[SB-1:0];
            voice = c_neg ? -vmag : vmag;
            car_phase       += car_inc_q;
            modulator_phase += mod_inc_q;
            env_prod  = {16'b0, env_level} * {16'b0, decay_q};
            env_level = env_prod[31:16];
            note_pos  = note_pos + 1'b1;
        end
        res.left  = clamp_sum(it.left, voice);
        res.right = clamp_sum(it.right, voice);
        res.voice = voice;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Drive the item channel and the result stall
    always @(negedge clk)
    begin
        mix_item_t nxt;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    func     <= nxt.op;
                    left_in  <= nxt.left;
                    right_in <= nxt.right;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Track register writes, predict accepted items, check results
    always @(posedge clk)
    begin
        mix_item_t   it;
        mix_result_t got;
        mix_result_t want;
        in_taken = 1'b0;
        if (!rst_n)
        begin
            car_inc_q       = '0;
            mod_inc_q       = '0;
            mod_index_q     = '0;
            amp_q           = '0;
            decay_q         = fmv_pkg::DECAY_RESET;
            note_len_q      = '0;
            car_phase       = '0;
            modulator_phase = '0;
            note_pos        = '0;
            env_level       = fmv_pkg::ENV_FULL;
        end
        else
        begin
            in_taken = in_valid && !in_stall;
            if (cfg_valid && cfg_ready)
            begin
                case (fmv_pkg::cfg_reg_t'(cfg_index))
                    fmv_pkg::CFG_CARRIER_INC:   car_inc_q   = cfg_data[31:0];
                    fmv_pkg::CFG_MODULATOR_INC: mod_inc_q   = cfg_data[31:0];
                    fmv_pkg::CFG_MOD_INDEX:     mod_index_q = cfg_data[15:0];
                    fmv_pkg::CFG_AMPLITUDE:     amp_q       = cfg_data[15:0];
                    fmv_pkg::CFG_DECAY:         decay_q     = cfg_data[15:0];
                    fmv_pkg::CFG_NOTE_LENGTH:   note_len_q  = cfg_data[LB-1:0];
                    default: ;
                endcase
            end
            if (in_taken)
            begin
                it.op    = fmv_pkg::op_t'(func);
                it.left  = left_in;
                it.right = right_in;
                expected_mix.push_back(step_voice(it));
            end
            if (out_valid && !out_stall)
            begin
                got.left  = left_out;
                got.right = right_out;
                got.voice = voice_sample;
                got.act   = active;
                if (expected_mix.size() == 0)
                begin
                    report_mismatch("result with no item outstanding");
                end
                else
                begin
                    want = expected_mix.pop_front();
                    if (got.left !== want.left)
                    begin
                        report_mismatch($sformatf("left_out %0d, want %0d",
                                                  got.left, want.left));
                    end
                    if (got.right !== want.right)
                    begin
                        report_mismatch($sformatf("right_out %0d, want %0d",
                                                  got.right, want.right));
                    end
                    if (got.voice !== want.voice)
                    begin
                        report_mismatch($sformatf("voice_sample %0d, want %0d",
                                                  got.voice, want.voice));
                    end
                    if (got.act !== want.act)
                    begin
                        report_mismatch($sformatf("active %b, want %b",
                                                  got.act, want.act));
                    end
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_item(input fmv_pkg::op_t op, input sample_t l, input sample_t r);
        mix_item_t it;
        it.op    = op;
        it.left  = l;
        it.right = r;
        pending_samples.push_back(it);
    endtask

    // Hold until every item has been answered, then let the engine settle
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pending_samples.size() != 0 || in_valid || expected_mix.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input fmv_pkg::cfg_reg_t idx,
                             input logic [fmv_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
    endtask

    task automatic cfg_release();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_voice(input bit [31:0] car, input bit [31:0] modu,
                               input bit [15:0] idx, input bit [15:0] amp,
                               input bit [15:0] decay, input bit [LB-1:0] len);
        cfg_write(fmv_pkg::CFG_CARRIER_INC, car);
        cfg_write(fmv_pkg::CFG_MODULATOR_INC, modu);
        cfg_write(fmv_pkg::CFG_MOD_INDEX, 32'(idx));
        cfg_write(fmv_pkg::CFG_AMPLITUDE, 32'(amp));
        cfg_write(fmv_pkg::CFG_DECAY, 32'(decay));
        cfg_write(fmv_pkg::CFG_NOTE_LENGTH, 32'(len));
        cfg_release();
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return sample_t'($signed($urandom_range(64))) - 32;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic bit [15:0] rand_gain();
        case ($urandom_range(9))
            0, 1:    return 16'hFFFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [31:0] rand_inc();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(32'h0100_0000));
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [15:0] rand_decay();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1, 2:    return 16'hFFFF;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(16'hFFFF, 16'd58000));
        endcase
    endfunction

    function automatic bit [LB-1:0] rand_length();
        case ($urandom_range(11))
            0:       return '0;
            1:       return LB'(1);
            2:       return '1;
            default: return LB'($urandom_range(48, 2));
        endcase
    endfunction

    initial
    begin
        bit [LB-1:0] len;
        int          count;
        int          ticks;
        bit          paused;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings leave the voice silent
        send_idle_pct  = 19;
        recv_stall_pct = 64;
        push_item(fmv_pkg::OP_TICK, S_MAX, S_MIN);
        push_item(fmv_pkg::OP_RESTART, S_MIN, S_MAX);
        push_item(fmv_pkg::OP_TICK, '0, -1);
        wait_drained();

        // Directed: quarter-cycle carrier drives the sum into both rails
        write_voice(32'h4000_0000, 32'h4000_0000, 16'h0000, 16'hFFFF, 16'hFFFF, LB'(6));
        push_item(fmv_pkg::OP_RESTART, '0, '0);
        push_item(fmv_pkg::OP_TICK, '0, '0);
        push_item(fmv_pkg::OP_TICK, S_MAX, S_MAX);
        push_item(fmv_pkg::OP_TICK, -1, 1);
        push_item(fmv_pkg::OP_TICK, S_MIN, S_MIN);
        push_item(fmv_pkg::OP_TICK, S_MAX, S_MIN);
        push_item(fmv_pkg::OP_TICK, 1, -2);
        push_item(fmv_pkg::OP_TICK, '0, '0);
        push_item(fmv_pkg::OP_RESTART, S_MIN, S_MAX);
        push_item(fmv_pkg::OP_TICK, 12345, -12345);
        wait_drained();

        // Directed: cut the note, then lengthen it with a wrapping deviation
        cfg_write(fmv_pkg::CFG_NOTE_LENGTH, 32'd1);
        cfg_release();
        push_item(fmv_pkg::OP_TICK, '0, '0);
        wait_drained();
        cfg_write(fmv_pkg::CFG_NOTE_LENGTH, 32'({LB{1'b1}}));
        cfg_write(fmv_pkg::CFG_MOD_INDEX, 32'h0000_FFFF);
        cfg_write(fmv_pkg::CFG_DECAY, 32'h0000_0000);
        cfg_release();
        push_item(fmv_pkg::OP_RESTART, 100, -100);
        push_item(fmv_pkg::OP_TICK, S_MAX, S_MIN);
        push_item(fmv_pkg::OP_TICK, '0, '0);
        push_item(fmv_pkg::OP_TICK, -7, 7);
        wait_drained();

        // Directed: full-range increments with zero gain
        write_voice(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0800, 16'h0000, 16'h8000, LB'(3));
        push_item(fmv_pkg::OP_RESTART, '0, '0);
        repeat (4) push_item(fmv_pkg::OP_TICK, rand_sample(), rand_sample());
        wait_drained();

        // Random phases: mostly whole notes, some noise and cut notes
        paused = 1'b0;
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct  = (ph < 2) ? 19 : (ph < 4) ? 64 : 0;
            recv_stall_pct = (ph < 2) ? 64 : (ph < 4) ? 19 : 0;
            len = rand_length();
            write_voice(rand_inc(), rand_inc(), rand_gain(), rand_gain(), rand_decay(), len);
            count = 0;
            while (count < 200)
            begin
                if ($urandom_range(9) == 0)
                begin
                    push_item(fmv_pkg::op_t'($urandom_range(1)), rand_sample(),
                              rand_sample());
                    count++;
                end
                else
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        ticks = $urandom_range((len > 64) ? 64 : int'(len));
                    end
                    else
                    begin
                        ticks = ((len > 60) ? 60 : int'(len)) + $urandom_range(3);
                    end
                    push_item(fmv_pkg::OP_RESTART, rand_sample(), rand_sample());
                    repeat (ticks) push_item(fmv_pkg::OP_TICK, rand_sample(), rand_sample());
                    count += ticks + 1;
                end
                // Let the pipeline empty once in mid phase
                if (ph == 1 && !paused && count >= 100)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/fmv_pkg.sv
rtl/fmv_sine_rom.sv
rtl/fmv_front.sv
rtl/fmv_back.sv
rtl/fm_two_operator_voice_unit.sv
verif/fm_two_operator_voice_unit_tb.sv
